>>> design/tdmm_pkg.sv
// ----------------------------------------------------------------------------
// tdmm_pkg: shared types and constants of the table driven Moore machine
// Request and result payloads, command codes, table write bundle and the
// result queue push bundle.
// ----------------------------------------------------------------------------
package tdmm_pkg;

   localparam int DEF_NUM_STATES  = 16;
   localparam int DEF_NUM_SYMBOLS = 16;

   localparam int FIELD_W = 4;   // state / symbol fields on the request
   localparam int BYTE_W  = 8;   // output symbol byte

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_WRITE_TRANS = 2'b00,
      CMD_WRITE_OUT   = 2'b01,
      CMD_START       = 2'b10,
      CMD_SYMBOL      = 2'b11
   } command_type;

   typedef struct packed {
      command_type         command;
      logic [FIELD_W-1:0]  state_index;
      logic [FIELD_W-1:0]  symbol_index;
      logic [FIELD_W-1:0]  next_state;
      logic                reject_mark;
      logic [BYTE_W-1:0]   output_value;
      logic                last;
   } tdmm_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   result_symbol;
      logic                rejected;
      logic                end_of_run;
   } tdmm_rsp_type;

   // table write request, range checks happen inside the table block
   typedef struct packed {
      logic                trans_en;
      logic                out_en;
      logic [FIELD_W-1:0]  state;
      logic [FIELD_W-1:0]  symbol;
      logic [FIELD_W-1:0]  next;
      logic                reject;
      logic [BYTE_W-1:0]   value;
   } tdmm_wr_type;

   // up to two results pushed per cycle
   typedef struct packed {
      logic [1:0]          count;
      tdmm_rsp_type        first;
      tdmm_rsp_type        second;
   } tdmm_push_type;

endpackage

>>> design/tdmm_req_if.sv
// ----------------------------------------------------------------------------
// tdmm_req_if: request channel
// Valid/ready channel carrying one request item per transfer.
// ----------------------------------------------------------------------------
interface tdmm_req_if import tdmm_pkg::*; ();

   logic         valid;
   logic         ready;
   tdmm_req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

>>> design/tdmm_rsp_if.sv
// ----------------------------------------------------------------------------
// tdmm_rsp_if: result channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface tdmm_rsp_if import tdmm_pkg::*; ();

   logic         valid;
   logic         ready;
   tdmm_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

>>> design/table_driven_moore_machine.sv
// ----------------------------------------------------------------------------
// table_driven_moore_machine: programmable Moore machine
// Stage 1 registers the request, stage 2 pushes its one or two results.
// Throughput: 1 item per cycle while request ready is high, set by the table
// read and state feedback; the queue hands out 1 result per cycle while taken.
// Reset: 2**(clog2(NUM_STATES)+clog2(NUM_SYMBOLS)) entry clearing pass (256).
// ----------------------------------------------------------------------------
module table_driven_moore_machine import tdmm_pkg::*; #(
   parameter int NUM_STATES  = DEF_NUM_STATES,
   parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
   input  logic       clock,
   input  logic       reset,
   tdmm_req_if.sink   req_bus,
   tdmm_rsp_if.source rsp_bus
);

   localparam int SW = $clog2(NUM_STATES);
   localparam int YW = $clog2(NUM_SYMBOLS);

   // what stage 1 keeps of an accepted request
   typedef struct packed {
      command_type command;
      logic        active;   // rejected flag was clear at transfer
      logic        sym_oob;  // symbol beyond the table: behaves as reject
      logic        last;
   } stage_type;

   // architectural state
   logic [SW-1:0]       state_ff, state_in;
   logic                rejected_ff, rejected_in;

   // stage 1: request registered, table read data arriving
   logic                s1_valid_ff;
   stage_type           s1_ff, s1_in;

   // stage 2: results assembled and pushed into the queue
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_second_ff, s2_second_in;
   logic                s2_reject_ff, s2_reject_in;
   logic [BYTE_W-1:0]   s2_cur_out_ff;

   // table block
   tdmm_wr_type         wr;
   logic                trans_reject;
   logic [SW-1:0]       trans_next;
   logic [BYTE_W-1:0]   cur_out, nxt_out;
   logic                tbl_busy;

   // queue
   tdmm_push_type       push;
   logic [QCNT_W-1:0]   q_count;
   logic [QCNT_W+1:0]   q_need;

   logic                accept;
   logic                s1_start, s1_symbol, s1_reject, s1_move;

   // ------------------------------------------------------------------------
   // Input transfer. Ready is held back while the tables are being cleared
   // and whenever the queue could not absorb the worst case of two results
   // from each item still in flight plus the one being taken.
   // ------------------------------------------------------------------------
   always_comb begin
      q_need = {2'b00, q_count} + (s1_valid_ff ? (QCNT_W+2)'(2) : '0)
             + (s2_valid_ff ? (QCNT_W+2)'(2) : '0) + (QCNT_W+2)'(2);
   end

   assign req_bus.ready = !tbl_busy && (32'(q_need) <= QUEUE_DEPTH);
   assign accept        = req_bus.valid & req_bus.ready;

   // ------------------------------------------------------------------------
   // Stage 1 decode. The transition entry read at transfer time is here now,
   // so the next state and the reject flag resolve in this cycle and are
   // forwarded to the table address of the request being taken right now.
   // ------------------------------------------------------------------------
   always_comb begin
      s1_start  = s1_valid_ff && (s1_ff.command == CMD_START);
      s1_symbol = s1_valid_ff && (s1_ff.command == CMD_SYMBOL) && s1_ff.active;
      s1_reject = s1_symbol && (trans_reject || s1_ff.sym_oob);
      s1_move   = s1_symbol && !s1_reject;

      state_in = state_ff;
      if (s1_start) begin
         state_in = '0;
      end else if (s1_move) begin
         state_in = trans_next;
      end

      rejected_in = rejected_ff;
      if (s1_start) begin
         rejected_in = 1'b0;
      end else if (s1_reject) begin
         rejected_in = 1'b1;
      end
   end

   always_comb begin
      s1_in.command = req_bus.data.command;
      s1_in.active  = !rejected_in;
      s1_in.sym_oob = 32'(req_bus.data.symbol_index) >= NUM_SYMBOLS;
      s1_in.last    = req_bus.data.last;

      // table writes land at the transfer edge; later reads see them
      wr.trans_en = accept && (req_bus.data.command == CMD_WRITE_TRANS);
      wr.out_en   = accept && (req_bus.data.command == CMD_WRITE_OUT);
      wr.state    = req_bus.data.state_index;
      wr.symbol   = req_bus.data.symbol_index;
      wr.next     = req_bus.data.next_state;
      wr.reject   = req_bus.data.reject_mark;
      wr.value    = req_bus.data.output_value;
   end

   // only live symbols produce results: one, or two on last / reject
   assign s2_valid_in  = s1_symbol;
   assign s2_second_in = s1_reject || s1_ff.last;
   assign s2_reject_in = s1_reject;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= '0;
         rejected_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rejected_ff <= rejected_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff         <= s1_in;
      s2_second_ff  <= s2_second_in;
      s2_reject_ff  <= s2_reject_in;
      s2_cur_out_ff <= cur_out;
   end

   // ------------------------------------------------------------------------
   // Tables: transition read at {forwarded state, symbol}, current output
   // read alongside it, next-state output read at the registered next state.
   // ------------------------------------------------------------------------
   tdmm_tables #(
      .NUM_STATES  (NUM_STATES),
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_tables (
      .clock        (clock),
      .reset        (reset),
      .wr           (wr),
      .rd_state     (state_in),
      .rd_symbol    (YW'(req_bus.data.symbol_index)),
      .nx_state     (trans_next),
      .trans_reject (trans_reject),
      .trans_next   (trans_next),
      .cur_out      (cur_out),
      .nxt_out      (nxt_out),
      .busy         (tbl_busy)
   );

   // ------------------------------------------------------------------------
   // Stage 2: current output first, then either the reject marker or the
   // output of the state reached, flagged end of run.
   // ------------------------------------------------------------------------
   always_comb begin
      push.count = 2'd0;
      if (s2_valid_ff) begin
         push.count = s2_second_ff ? 2'd2 : 2'd1;
      end
      push.first.result_symbol  = s2_cur_out_ff;
      push.first.rejected       = 1'b0;
      push.first.end_of_run     = 1'b0;
      push.second.result_symbol = s2_reject_ff ? '0 : nxt_out;
      push.second.rejected      = s2_reject_ff;
      push.second.end_of_run    = 1'b1;
   end

   tdmm_result_queue u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .count   (q_count),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> design/tdmm_tables.sv
// ----------------------------------------------------------------------------
// tdmm_tables: transition and output tables
// Transition memory with one registered read port, output memory with two
// registered read ports, and the clearing pass that runs after reset.
// ----------------------------------------------------------------------------
module tdmm_tables import tdmm_pkg::*; #(
   parameter int  NUM_STATES  = DEF_NUM_STATES,
   parameter int  NUM_SYMBOLS = DEF_NUM_SYMBOLS,
   localparam int SW          = $clog2(NUM_STATES),
   localparam int YW          = $clog2(NUM_SYMBOLS)
) (
   input  logic              clock,
   input  logic              reset,
   input  tdmm_wr_type       wr,
   input  logic [SW-1:0]     rd_state,
   input  logic [YW-1:0]     rd_symbol,
   input  logic [SW-1:0]     nx_state,
   output logic              trans_reject,
   output logic [SW-1:0]     trans_next,
   output logic [BYTE_W-1:0] cur_out,
   output logic [BYTE_W-1:0] nxt_out,
   output logic              busy
);

   localparam int AW     = SW + YW;
   localparam int TDEPTH = 2 ** AW;
   localparam int ODEPTH = 2 ** SW;

   // entry: {reject, next state}
   logic [SW:0]        trans_mem [TDEPTH];
   logic [BYTE_W-1:0]  out_mem   [ODEPTH];

   logic               clr_busy_ff, clr_busy_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;

   logic [SW:0]        trans_rd_ff;
   logic [BYTE_W-1:0]  cur_out_ff;
   logic [BYTE_W-1:0]  nxt_out_ff;

   logic               t_in_range, t_reject, t_we;
   logic [AW-1:0]      t_waddr;
   logic [SW:0]        t_wdata;
   logic               o_we;
   logic [SW-1:0]      o_waddr;
   logic [BYTE_W-1:0]  o_wdata;

   // clearing pass: every transition entry becomes a reject mark, every output entry zero
   assign clr_addr_in = clr_addr_ff + AW'(1);
   assign clr_busy_in = clr_busy_ff & (clr_addr_ff != '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      t_in_range = (32'(wr.state) < NUM_STATES) && (32'(wr.symbol) < NUM_SYMBOLS);
      t_reject   = wr.reject | (32'(wr.next) >= NUM_STATES);
      t_we       = clr_busy_ff | (wr.trans_en & t_in_range);
      t_waddr    = clr_busy_ff ? clr_addr_ff : {SW'(wr.state), YW'(wr.symbol)};
      t_wdata    = (clr_busy_ff | t_reject) ? {1'b1, {SW{1'b0}}} : {1'b0, SW'(wr.next)};

      o_we       = clr_busy_ff | (wr.out_en & (32'(wr.state) < NUM_STATES));
      o_waddr    = clr_busy_ff ? clr_addr_ff[AW-1:YW] : SW'(wr.state);
      o_wdata    = clr_busy_ff ? '0 : wr.value;
   end

   always_ff @(posedge clock) begin
      if (t_we) begin
         trans_mem[t_waddr] <= t_wdata;
      end
      trans_rd_ff <= trans_mem[{rd_state, rd_symbol}];
   end

   always_ff @(posedge clock) begin
      if (o_we) begin
         out_mem[o_waddr] <= o_wdata;
      end
      cur_out_ff <= out_mem[rd_state];
      nxt_out_ff <= out_mem[nx_state];
   end

   assign trans_reject = trans_rd_ff[SW];
   assign trans_next   = trans_rd_ff[SW-1:0];
   assign cur_out      = cur_out_ff;
   assign nxt_out      = nxt_out_ff;
   assign busy         = clr_busy_ff;

endmodule

>>> design/tdmm_result_queue.sv
// ----------------------------------------------------------------------------
// tdmm_result_queue: result FIFO
// Takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module tdmm_result_queue import tdmm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  tdmm_push_type     push,
   output logic [QCNT_W-1:0] count,
   tdmm_rsp_if.source        rsp_bus
);

   tdmm_rsp_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;

   assign pop       = rsp_bus.valid & rsp_bus.ready;
   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + QPTR_W'(1)] <= push.second;
      end
   end

   assign rsp_bus.valid = (count_ff != '0);
   assign rsp_bus.data  = entries_ff[rd_ptr_ff];
   assign count         = count_ff;

endmodule
